[rtl/core/urs_pkg.sv]
// Shared types and constants for the uniform rejection sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package urs_pkg;

	localparam int unsigned MAX_COEFFS = 256;
	localparam int unsigned CNT_W      = 9;
	localparam int unsigned COEFF_W    = 23;
	localparam int unsigned POS_W      = 8;
	localparam int unsigned QDEPTH     = 4;
	localparam int unsigned QPTR_W     = 2;
	localparam int unsigned QCNT_W     = 3;

	localparam logic [COEFF_W-1:0] SAMPLER_Q = 23'd8380417;
	localparam logic [CNT_W-1:0]   LIMIT_MAX = CNT_W'(MAX_COEFFS);

	localparam logic [1:0] PH_B0 = 2'd0;
	localparam logic [1:0] PH_B1 = 2'd1;
	localparam logic [1:0] PH_B2 = 2'd2;

	localparam logic REG_TARGET = 1'b0;

	typedef struct packed {
		logic               coeff_valid;
		logic [COEFF_W-1:0] coefficient;
		logic [POS_W-1:0]   position;
		logic               run_done;
		logic [CNT_W-1:0]   written_count;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t res;
	} push_t;

endpackage

`default_nettype wire

[rtl/core/uniform_rejection_sampler_unit.sv]
// Top level of the uniform rejection sampler: APB register, front end and
// result queue. Depends on urs_pkg, urs_front and urs_queue.
`default_nettype none

// One byte is taken per cycle whenever the four-entry result queue has room;
// a result is written into the queue as its byte is transferred and reaches
// the output once older results are taken. Throughput is one byte per cycle
// as long as the consumer drains results; only a full queue stalls input.
// Register target_count (byte address 0, reset 256) caps the coefficients
// per buffer at min(target_count, 256); write it only while idle.

module uniform_rejection_sampler_unit import urs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    coeff_valid,
	output logic      [COEFF_W-1:0] coefficient,
	output logic      [POS_W-1:0]   position,
	output logic                    run_done,
	output logic      [CNT_W-1:0]   written_count
);

	logic [CNT_W-1:0] target_q;
	logic             full;
	push_t            wr;
	result_t          rd;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_TARGET) ? {{(32-CNT_W){1'b0}}, target_q} : '0;
	assign in_ready = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= LIMIT_MAX;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET)) begin
			target_q <= pwdata[CNT_W-1:0];
		end
	end

	urs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_valid && in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.target_count (target_q),
		.wr           (wr)
	);

	urs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rd        (rd)
	);

	assign coeff_valid   = rd.coeff_valid;
	assign coefficient   = rd.coefficient;
	assign position      = rd.position;
	assign run_done      = rd.run_done;
	assign written_count = rd.written_count;

endmodule

`default_nettype wire

[rtl/core/urs_front.sv]
// Front end: gathers bytes into 23-bit candidates, tests them against q,
// tracks the per-buffer count and emits result records. Uses urs_pkg.
`default_nettype none

module urs_front import urs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic [CNT_W-1:0] target_count,
	output push_t                 wr
);

	logic [1:0]         phase_q;
	logic [15:0]        partial_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   limit;
	logic               active;
	logic [COEFF_W-1:0] cand;
	logic               got;

	assign limit  = (target_count > LIMIT_MAX) ? LIMIT_MAX : target_count;
	assign active = count_q < limit;
	assign cand   = {data_byte[6:0], partial_q};
	assign got    = active && (phase_q == PH_B2) && (cand < SAMPLER_Q);

	always_comb begin
		wr.push                  = accept && (got || last_byte);
		wr.res.coeff_valid       = got;
		wr.res.coefficient       = got ? cand : '0;
		wr.res.position          = got ? count_q[POS_W-1:0] : '0;
		wr.res.run_done          = last_byte;
		wr.res.written_count     = count_q + CNT_W'(got);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_B0;
			partial_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q   <= PH_B0;
				partial_q <= '0;
				count_q   <= '0;
			end else if (active) begin
				unique case (phase_q)
					PH_B0: begin
						partial_q <= {8'h00, data_byte};
						phase_q   <= PH_B1;
					end
					PH_B1: begin
						partial_q[15:8] <= data_byte;
						phase_q         <= PH_B2;
					end
					default: begin
						phase_q <= PH_B0;
						if (got)
							count_q <= count_q + CNT_W'(1);
					end
				endcase
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT_MAX)
		else $error("accepted count above maximum");
	a_coeff_below_q: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push && wr.res.coeff_valid |-> wr.res.coefficient < SAMPLER_Q)
		else $error("coefficient not below q");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> count_q == '0 && phase_q == PH_B0)
		else $error("buffer end did not clear state");

endmodule

`default_nettype wire

[rtl/core/urs_queue.sv]
// Back end: short result queue that decouples the sampler from the
// output consumer and drives the result channel. Uses urs_pkg.
`default_nettype none

module urs_queue import urs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t wr,
	output logic       full,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    rd
);

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign full      = cnt_q == QCNT_W'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign rd        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr.push)
			mem_q[wptr_q] <= wr.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr.push)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			case ({wr.push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full)
		else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(wptr_q - rptr_q) == cnt_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for uniform_rejection_sampler_unit: random byte buffers in,
// coefficients out, scored against an in-bench sampler model.
// Depends on urs_pkg and the RTL of the block.
`default_nettype none

module tb_top import urs_pkg::*; ();

	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned STALL_LIMIT   = 2000;

	class sampler_scoreboard;
		logic [CNT_W-1:0] target_reg;
		logic [1:0]       gather_phase;
		logic [15:0]      low_bytes;
		logic [CNT_W-1:0] coeff_count;
		result_t          expected_results[$];
		int unsigned      errors;

		function new();
			target_reg   = LIMIT_MAX;
			gather_phase = PH_B0;
			low_bytes    = '0;
			coeff_count  = '0;
			errors       = 0;
		endfunction

		function void set_target(logic [CNT_W-1:0] v);
			target_reg = v;
		endfunction

		function void note_byte(logic [7:0] b, logic lst);
			logic [CNT_W-1:0] lim;
			logic [23:0]      cand;
			result_t          r;
			bit               got;
			lim = (target_reg > LIMIT_MAX) ? LIMIT_MAX : target_reg;
			r   = '0;
			got = 1'b0;
			if (coeff_count < lim) begin
				case (gather_phase)
					PH_B0: begin
						low_bytes    = {8'h00, b};
						gather_phase = PH_B1;
					end
					PH_B1: begin
						low_bytes    = {b, low_bytes[7:0]};
						gather_phase = PH_B2;
					end
					default: begin
						cand         = {b, low_bytes};
						gather_phase = PH_B0;
						if (cand[COEFF_W-1:0] < SAMPLER_Q) begin
							got           = 1'b1;
							r.coefficient = cand[COEFF_W-1:0];
							r.position    = coeff_count[POS_W-1:0];
							coeff_count   = coeff_count + CNT_W'(1);
						end
					end
				endcase
			end
			if (got || lst) begin
				r.coeff_valid   = got;
				r.run_done      = lst;
				r.written_count = coeff_count;
				expected_results.push_back(r);
			end
			if (lst) begin
				gather_phase = PH_B0;
				low_bytes    = '0;
				coeff_count  = '0;
			end
		endfunction

		function void field_check(string fname, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t act);
			result_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: result expected none actual %0h", $time, act);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				field_check("coeff_valid", 32'(exp_r.coeff_valid), 32'(act.coeff_valid));
				field_check("coefficient", 32'(exp_r.coefficient), 32'(act.coefficient));
				field_check("position", 32'(exp_r.position), 32'(act.position));
				field_check("run_done", 32'(exp_r.run_done), 32'(act.run_done));
				field_check("written_count", 32'(exp_r.written_count),
					32'(act.written_count));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic               out_valid;
	logic               out_ready;
	logic               coeff_valid;
	logic [COEFF_W-1:0] coefficient;
	logic [POS_W-1:0]   position;
	logic               run_done;
	logic [CNT_W-1:0]   written_count;

	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned stall_cycles;

	sampler_scoreboard sb = new();

	uniform_rejection_sampler_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.coeff_valid(coeff_valid),
		.coefficient(coefficient),
		.position(position),
		.run_done(run_done),
		.written_count(written_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(data_byte, last_byte);
			if (out_valid && out_ready)
				sb.check_result({coeff_valid, coefficient, position, run_done, written_count});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	// let the scoreboard note the last transfer before checking for drain
	task automatic wait_drained();
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle_for_config();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write, then read back over the same select
	task automatic write_target(input logic [CNT_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_TARGET, 2'b00};
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_target(v);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CNT_W-1:0] !== v) begin
			$display("%0t: target_count expected %0h actual %0h", $time, v,
				prdata[CNT_W-1:0]);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [23:0] pick_candidate(int unsigned near_pct);
		if ($urandom_range(99) >= near_pct)
			return 24'($urandom);
		case ($urandom_range(5))
			0: return {1'b0, SAMPLER_Q};
			1: return {1'b0, SAMPLER_Q - 23'd1};
			2: return {1'($urandom_range(1)), 23'h7FFFFF};
			3: return {1'($urandom_range(1)), 23'h000000};
			4: return {1'($urandom_range(1)), SAMPLER_Q + 23'($urandom_range(8190))};
			default: return 24'($urandom) | 24'h800000;
		endcase
	endfunction

	task automatic send_buffer(input int unsigned len, input int unsigned near_pct);
		logic [23:0] cand;
		for (int unsigned i = 0; i < len; i++) begin
			if (i % 3 == 0)
				cand = pick_candidate(near_pct);
			send_byte(cand[8*(i%3) +: 8], i == len - 1);
		end
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] tgt, input int unsigned budget,
			input int unsigned min_len, input int unsigned max_len,
			input int unsigned near_pct);
		int unsigned sent;
		int unsigned len;
		settle_for_config();
		write_target(tgt);
		sent = 0;
		while (sent < budget) begin
			len = $urandom_range(max_len, min_len);
			if (len > budget - sent)
				len = budget - sent;
			send_buffer(len, near_pct);
			sent += len;
			if ($urandom_range(7) == 0) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		out_ready <= 1'b0;
		send_idle = 12;
		recv_idle = 64;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset target: lone last byte, accept, q, q-1, 23-bit mask, bit 23 drop
		send_byte(8'h5A, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hBB, 1'b1);
		in_valid <= 1'b0;

		// target reached, then bytes ignored
		settle_for_config();
		write_target(9'd1);
		send_byte(8'h10, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(8'h40, 1'b1);
		in_valid <= 1'b0;

		settle_for_config();
		write_target(9'd0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b1);
		in_valid <= 1'b0;

		run_phase(CNT_W'($urandom_range(40, 2)), 180, 1, 40, 15);
		run_phase(9'd300, 80, 1, 60, 10);

		send_idle = 64;
		recv_idle = 12;
		run_phase(9'd0, 30, 1, 12, 10);
		run_phase(CNT_W'($urandom_range(255, 1)), 160, 1, 90, 15);
		run_phase(9'd256, 60, 1, 30, 10);

		send_idle = 0;
		recv_idle = 0;
		run_phase(9'd511, 810, 810, 810, 3);
		run_phase(9'd1, 60, 1, 10, 20);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/core/urs_pkg.sv
rtl/core/urs_front.sv
rtl/core/urs_queue.sv
rtl/core/uniform_rejection_sampler_unit.sv
tb/tb_top.sv
